// ----- sv/life_automaton_generation_engine_defines.svh -----
// Assertion macros for the life automaton generation engine.
// Depends on nothing; the macros expect clk_i and rst_ni in scope.
`ifndef LIFE_AUTOMATON_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_AUTOMATON_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LAGE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LAGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lage_pkg.sv -----
// Package for the life automaton generation engine: grid sizes, codes,
// sequencer states and the neighbor count helper. Depends on nothing.
`default_nettype none

package lage_pkg;

  // Grid geometry.
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_AW    = $clog2(GRID_ROWS);
  localparam int COL_AW    = $clog2(GRID_COLS);
  localparam int CNT_W     = $clog2(GRID_ROWS + 1);

  // Field widths.
  localparam int REQ_W  = 2;
  localparam int FROW_W = 6;
  localparam int FCOL_W = 6;
  localparam int BND_W  = 4;
  localparam int CIDX_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SURVIVE_MIN = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SURVIVE_MAX = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BIRTH_MIN   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BIRTH_MAX   = 3'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_FINISH
  } lage_state_e;

  // Number of live cells among eight neighbors.
  function automatic logic [3:0] nb_count(input logic [7:0] nb);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 4'(nb[i]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- sv/life_automaton_generation_engine.sv -----
// Life automaton generation engine: a cell grid with write, read and advance.
// Depends on lage_pkg and life_automaton_generation_engine_defines.svh.
`default_nettype none
`include "life_automaton_generation_engine_defines.svh"

// The block keeps a GRID_ROWS x GRID_COLS grid of cells in a row-wide memory
// and takes one item at a time. A cell write or read goes from acceptance to
// the result through the memory read, the pick or merge of the cell in
// ST_CELL and the load of the result register in ST_FINISH, held while a
// stalled result waits. In an advance, rows stream out of the single read port one
// per cycle into a three-row window, the shared row unit computes one new
// interior row per cycle and writes it back two rows behind the read. The
// edge ring is kept as it is. Reset clears the grid at once through one valid
// bit per row, so there is no clearing pass. Request type 3 is taken and
// dropped with no result. Configuration writes are always ready.
module life_automaton_generation_engine (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [lage_pkg::REQ_W-1:0]    req_type_i,
  input  wire  [lage_pkg::FROW_W-1:0]   cell_row_i,
  input  wire  [lage_pkg::FCOL_W-1:0]   cell_col_i,
  input  wire                           cell_value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          read_value_o,
  output logic [lage_pkg::REQ_W-1:0]    done_kind_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [lage_pkg::CIDX_W-1:0]   cfg_index_i,
  input  wire  [lage_pkg::BND_W-1:0]    cfg_data_i
);
  import lage_pkg::*;

  lage_state_e state_q, state_d;

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [REQ_W-1:0]     kind_q;
  logic [ROW_AW-1:0]    row_q;
  logic [COL_AW-1:0]    col_q;
  logic                 val_q;
  logic                 in_range_q;
  logic                 res_bit_q, res_bit_d;

  logic [BND_W-1:0]     s_min_q, s_max_q, b_min_q, b_max_q;

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid_q;
  logic [GRID_COLS-1:0] rdata_raw_q;
  logic                 rvalid_q;
  logic [GRID_COLS-1:0] rdata;
  logic [ROW_AW-1:0]    rd_addr;
  logic                 we;
  logic [ROW_AW-1:0]    wr_addr;
  logic [GRID_COLS-1:0] wr_data;

  logic [GRID_COLS-1:0] up_q, mid_q;
  logic [GRID_COLS-1:0] new_row;
  logic [GRID_COLS-1:0] merged_row;

  logic                 accept;
  logic                 load_out;
  logic                 out_valid_q;
  logic                 read_value_q;
  logic [REQ_W-1:0]     done_kind_q;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_min_q <= 4'd2;
      s_max_q <= 4'd3;
      b_min_q <= 4'd3;
      b_max_q <= 4'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SURVIVE_MIN: s_min_q <= cfg_data_i;
        CFG_SURVIVE_MAX: s_max_q <= cfg_data_i;
        CFG_BIRTH_MIN:   b_min_q <= cfg_data_i;
        CFG_BIRTH_MAX:   b_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Grid memory: one read port with registered data, one write port.
  always_ff @(posedge clk_i) begin
    rdata_raw_q <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Row valid bits; a row never written since reset reads as all dead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      rvalid_q <= row_valid_q[rd_addr];
      if (we) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid_q ? rdata_raw_q : '0;

  // Shared row unit: next generation of the window's middle row.
  always_comb begin
    logic [3:0] n;
    logic       live;
    new_row = '0;
    new_row[0]           = mid_q[0];
    new_row[GRID_COLS-1] = mid_q[GRID_COLS-1];
    for (int c = 1; c < GRID_COLS - 1; c++) begin
      n = nb_count({up_q[c-1], up_q[c], up_q[c+1], mid_q[c-1], mid_q[c+1],
                    rdata[c-1], rdata[c], rdata[c+1]});
      live = mid_q[c];
      new_row[c] = live ? (n >= s_min_q && n <= s_max_q)
                        : (n >= b_min_q && n <= b_max_q);
    end
  end

  // Cell write merges one bit into the fetched row.
  always_comb begin
    merged_row        = rdata;
    merged_row[col_q] = val_q;
  end

  // Sequencer state and item capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= req_type_i;
      row_q      <= ROW_AW'(cell_row_i);
      col_q      <= COL_AW'(cell_col_i);
      val_q      <= cell_value_i;
      in_range_q <= (int'(cell_row_i) < GRID_ROWS) && (int'(cell_col_i) < GRID_COLS);
    end
    res_bit_q <= res_bit_d;
    if (state_q == ST_ADV) begin
      up_q  <= mid_q;
      mid_q <= rdata;
    end
  end

  // Next state, memory addressing and write control.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_bit_d = res_bit_q;
    rd_addr   = ROW_AW'(cell_row_i);
    we        = 1'b0;
    wr_addr   = row_q;
    wr_data   = merged_row;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_WRITE, REQ_READ: state_d = ST_CELL;
            REQ_ADVANCE: begin
              rd_addr = '0;
              cnt_d   = CNT_W'(1);
              state_d = ST_ADV;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CELL: begin
        res_bit_d = (kind_q == REQ_READ) && in_range_q && rdata[col_q];
        we        = (kind_q == REQ_WRITE) && in_range_q;
        state_d   = ST_FINISH;
      end
      ST_ADV: begin
        rd_addr = cnt_q[ROW_AW-1:0];
        wr_addr = ROW_AW'(cnt_q - CNT_W'(2));
        wr_data = new_row;
        we      = (cnt_q >= CNT_W'(3));
        res_bit_d = 1'b0;
        if (cnt_q == CNT_W'(GRID_ROWS)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      read_value_q <= res_bit_q;
      done_kind_q  <= kind_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign done_kind_o  = done_kind_q;

  // Checks on the sequencer.
  `LAGE_ASSERT_NEXT(a_adv_holds_input, accept && (req_type_i == REQ_ADVANCE), in_stall_o, "advance accepted but input not stalled")
  `LAGE_ASSERT_SAME(a_we_source, we, ((state_q == ST_ADV) && (cnt_q >= CNT_W'(3))) || ((state_q == ST_CELL) && (kind_q == REQ_WRITE)), "grid written outside advance or cell write")
  `LAGE_ASSERT_SAME(a_cnt_bound, state_q == ST_ADV, (cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(GRID_ROWS)), "advance row counter out of range")
  `LAGE_ASSERT_NEXT(a_out_from_finish, load_out, out_valid_o && (state_q == ST_IDLE), "result loaded but not presented")

endmodule

`default_nettype wire

// ----- bench/life_automaton_generation_engine_tb.sv -----
// Self-checking testbench for the life automaton generation engine.
// Depends on lage_pkg and the life_automaton_generation_engine RTL; a grid
// tracker class predicts every completion, and plain tasks drive the ports.
`default_nettype none

module life_automaton_generation_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lage_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 62;
  localparam int SETTLE_DELAY = GRID_ROWS + 16;

  typedef struct packed {
    logic             read_value;
    logic [REQ_W-1:0] done_kind;
  } completion_t;

  // Tracks the cell grid and the rule bounds, and queues the completion that
  // each accepted item should produce.
  class life_grid_tracker;
    logic [GRID_COLS-1:0] cells [GRID_ROWS];
    logic [BND_W-1:0]     survive_min = 4'd2;
    logic [BND_W-1:0]     survive_max = 4'd3;
    logic [BND_W-1:0]     birth_min   = 4'd3;
    logic [BND_W-1:0]     birth_max   = 4'd3;
    completion_t          pending_completions [$];
    int                   mismatches = 0;

    function new();
      foreach (cells[r]) cells[r] = '0;
    endfunction

    function int outstanding();
      return pending_completions.size();
    endfunction

    function void set_bound(logic [CIDX_W-1:0] idx, logic [BND_W-1:0] val);
      case (idx)
        CFG_SURVIVE_MIN: survive_min = val;
        CFG_SURVIVE_MAX: survive_max = val;
        CFG_BIRTH_MIN:   birth_min   = val;
        CFG_BIRTH_MAX:   birth_max   = val;
        default: ;
      endcase
    endfunction

    // One generation: the interior is rebuilt from a fresh all-dead grid,
    // while the edge ring keeps its cells.
    function void step_generation();
      logic [GRID_COLS-1:0] fresh [GRID_ROWS];
      int                   n;
      logic                 keep;
      foreach (fresh[r]) fresh[r] = '0;
      for (int r = 1; r < GRID_ROWS - 1; r++) begin
        for (int c = 1; c < GRID_COLS - 1; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) n += int'(cells[r + dr][c + dc]);
            end
          end
          if (cells[r][c]) begin
            keep = (n >= survive_min) && (n <= survive_max);
          end else begin
            keep = (n >= birth_min) && (n <= birth_max);
          end
          fresh[r][c] = keep;
        end
      end
      for (int r = 1; r < GRID_ROWS - 1; r++) begin
        for (int c = 1; c < GRID_COLS - 1; c++) begin
          cells[r][c] = fresh[r][c];
        end
      end
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [FROW_W-1:0] row,
                               logic [FCOL_W-1:0] col, logic val);
      completion_t want;
      want.read_value = 1'b0;
      want.done_kind  = kind;
      case (kind)
        REQ_WRITE: begin
          if (row < GRID_ROWS && col < GRID_COLS) cells[row][col] = val;
        end
        REQ_READ: begin
          if (row < GRID_ROWS && col < GRID_COLS) want.read_value = cells[row][col];
        end
        REQ_ADVANCE: step_generation();
        default: return;
      endcase
      pending_completions.push_back(want);
    endfunction

    function void check_completion(logic rd, logic [REQ_W-1:0] kind);
      completion_t want;
      if (pending_completions.size() == 0) begin
        $display("%0t: unexpected completion, read_value %0d done_kind %0d",
                 $time, rd, kind);
        mismatches++;
        return;
      end
      want = pending_completions.pop_front();
      if (rd !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, want.read_value, rd);
        mismatches++;
      end
      if (kind !== want.done_kind) begin
        $display("%0t: done_kind expected %0d actual %0d", $time, want.done_kind, kind);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type     = REQ_WRITE;
  logic [FROW_W-1:0]   cell_row     = '0;
  logic [FCOL_W-1:0]   cell_col     = '0;
  logic                cell_value   = 1'b0;
  logic                out_valid_o;
  logic                out_stall    = 1'b0;
  logic                read_value_o;
  logic [REQ_W-1:0]    done_kind_o;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index    = CFG_SURVIVE_MIN;
  logic [BND_W-1:0]    cfg_data     = '0;
  bit                  steady       = 1'b0;

  life_grid_tracker grid = new();

  life_automaton_generation_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type),
    .cell_row_i   (cell_row),
    .cell_col_i   (cell_col),
    .cell_value_i (cell_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .read_value_o (read_value_o),
    .done_kind_o  (done_kind_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Free-running 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The result side stalls at random except during the steady stretch.
  always @(negedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 16);
  end

  // Every accepted item updates the predicted grid.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall_o) begin
      grid.note_request(req_type, cell_row, cell_col, cell_value);
    end
  end

  // Every accepted completion is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) begin
      grid.check_completion(read_value_o, done_kind_o);
    end
  end

  // Ends the run when no handshake of any kind happens for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready_o === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one item and returns at the falling edge after its acceptance.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [FROW_W-1:0] row,
                              input logic [FCOL_W-1:0] col, input logic val);
    if (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    cell_row   <= row;
    cell_col   <= col;
    cell_value <= val;
    do @(posedge clk_i); while (!(in_valid && !in_stall_o));
    @(negedge clk_i);
  endtask

  // Waits for every predicted completion, then lets the block rest before it
  // is touched again.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (grid.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_DELAY) @(negedge clk_i);
  endtask

  // Writes all four rule bounds back to back; the block must be idle.
  task automatic load_rule(input logic [BND_W-1:0] smin, input logic [BND_W-1:0] smax,
                           input logic [BND_W-1:0] bmin, input logic [BND_W-1:0] bmax);
    logic [CIDX_W-1:0] regs [4];
    logic [BND_W-1:0]  vals [4];
    regs = '{CFG_SURVIVE_MIN, CFG_SURVIVE_MAX, CFG_BIRTH_MIN, CFG_BIRTH_MAX};
    vals = '{smin, smax, bmin, bmax};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      grid.set_bound(regs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               phase_items;
    int               r0;
    int               c0;
    logic [REQ_W-1:0] kind;

    repeat (7) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset rule: corners of the edge ring, a
    // blinker, a cluster touching a corner, an unused request type, reads.
    send_request(REQ_READ,  6'd0,  6'd0,  1'b0);
    send_request(REQ_WRITE, 6'd0,  6'd0,  1'b1);
    send_request(REQ_WRITE, 6'd63, 6'd63, 1'b1);
    send_request(REQ_WRITE, 6'd0,  6'd63, 1'b1);
    send_request(REQ_WRITE, 6'd63, 6'd0,  1'b1);
    send_request(REQ_WRITE, 6'd10, 6'd9,  1'b1);
    send_request(REQ_WRITE, 6'd10, 6'd10, 1'b1);
    send_request(REQ_WRITE, 6'd10, 6'd11, 1'b1);
    send_request(REQ_WRITE, 6'd1,  6'd1,  1'b1);
    send_request(REQ_WRITE, 6'd1,  6'd2,  1'b1);
    send_request(REQ_WRITE, 6'd2,  6'd1,  1'b1);
    send_request(REQ_NONE,  6'd63, 6'd63, 1'b1);
    send_request(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_request(REQ_READ,  6'd0,  6'd0,  1'b0);
    send_request(REQ_READ,  6'd63, 6'd63, 1'b0);
    send_request(REQ_READ,  6'd9,  6'd10, 1'b0);
    send_request(REQ_READ,  6'd10, 6'd10, 1'b0);
    send_request(REQ_READ,  6'd11, 6'd10, 1'b0);
    send_request(REQ_READ,  6'd10, 6'd9,  1'b0);
    send_request(REQ_READ,  6'd2,  6'd2,  1'b0);
    send_request(REQ_READ,  6'd1,  6'd1,  1'b0);
    send_request(REQ_WRITE, 6'd10, 6'd10, 1'b0);
    send_request(REQ_ADVANCE, 6'd63, 6'd63, 1'b1);
    send_request(REQ_READ,  6'd10, 6'd9,  1'b0);
    drain_block();

    // Random phases, each loading its rule first; the extremes follow the reset rule.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_rule(4'd2, 4'd3, 4'd3, 4'd3);
        1: load_rule(4'd0, 4'd0, 4'd0, 4'd0);
        2: load_rule(4'd15, 4'd15, 4'd15, 4'd15);
        3: load_rule(4'd0, 4'd15, 4'd0, 4'd15);
        4: load_rule(4'd3, 4'd2, 4'd5, 4'd1);
        5: load_rule(4'd1, 4'd4, 4'd3, 4'd6);
        6: load_rule(4'd2, 4'd3, 4'd3, 4'd3);
        default: load_rule(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      steady = (phase == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          // Seed an 8x8 window, often against the edge ring, advance, read back.
          if ($urandom_range(0, 3) == 0) begin
            r0 = $urandom_range(0, 1) ? 0 : GRID_ROWS - 8;
          end else begin
            r0 = $urandom_range(0, GRID_ROWS - 8);
          end
          if ($urandom_range(0, 3) == 0) begin
            c0 = $urandom_range(0, 1) ? 0 : GRID_COLS - 8;
          end else begin
            c0 = $urandom_range(0, GRID_COLS - 8);
          end
          repeat ($urandom_range(4, 14)) begin
            send_request(REQ_WRITE, FROW_W'(r0 + $urandom_range(0, 7)),
                         FCOL_W'(c0 + $urandom_range(0, 7)), $urandom_range(0, 3) != 0);
            phase_items++;
          end
          repeat ($urandom_range(1, 2)) begin
            send_request(REQ_ADVANCE, FROW_W'($urandom), FCOL_W'($urandom), 1'($urandom));
            phase_items++;
          end
          repeat ($urandom_range(6, 12)) begin
            send_request(REQ_READ, FROW_W'(r0 + $urandom_range(0, 7)),
                         FCOL_W'(c0 + $urandom_range(0, 7)), 1'($urandom));
            phase_items++;
          end
        end else begin
          // A lone item with every field random, the unused type included.
          kind = REQ_W'($urandom_range(0, 3));
          send_request(kind, FROW_W'($urandom), FCOL_W'($urandom), 1'($urandom));
          if (kind != REQ_NONE) phase_items++;
        end
      end
      steady = 1'b0;
      drain_block();
    end

    if (grid.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
